FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the position PID drive modules.
// The macros expect a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/core/pospid_pkg.sv
// ----------------------------------------------------------------------------
// Position PID drive package
// Widths, reset values, register indexes and stage word types shared by the
// position PID drive modules.
// ----------------------------------------------------------------------------
package pospid_pkg;

	// Field and register widths.
	localparam int POS_W   = 32;
	localparam int GAIN_W  = 24;
	localparam int LIMIT_W = 16;
	localparam int DRIVE_W = LIMIT_W + 1;
	localparam int CFG_IDX_W = 2;

	// Gain format and integral accumulator width.
	localparam int GAIN_FRAC_BITS = 8;
	localparam int INTEGRAL_WIDTH = 48;

	// Error and error-difference widths.
	localparam int ERR_W  = POS_W + 1;
	localparam int DIFF_W = ERR_W + 1;
	localparam int ISUM_W = INTEGRAL_WIDTH + 1;

	// Integral product is split into a signed upper half and an unsigned lower half.
	localparam int INT_LO_W   = INTEGRAL_WIDTH / 2;
	localparam int INT_HI_W   = INTEGRAL_WIDTH - INT_LO_W;
	localparam int HI_PROD_W  = INT_HI_W + GAIN_W + 1;
	localparam int LO_PROD_W  = INT_LO_W + GAIN_W;
	localparam int I_FULL_W   = INTEGRAL_WIDTH + GAIN_W + 1;

	// The integral term is held at plus or minus two to the power HUGE_EXP.
	localparam int HUGE_EXP  = 60;
	localparam int I_TERM_W  = HUGE_EXP + 2;
	localparam int CMP_W     = (I_FULL_W > I_TERM_W) ? I_FULL_W : I_TERM_W;

	// Proportional, derivative and total sum widths.
	localparam int P_W    = ERR_W + GAIN_W + 1;
	localparam int D_W    = DIFF_W + GAIN_W + 1;
	localparam int PD_W   = D_W + 1;
	localparam int SUM_W  = ((PD_W > I_TERM_W) ? PD_W : I_TERM_W) + 1;
	localparam int Q_W    = SUM_W - GAIN_FRAC_BITS;

	// Register reset values.
	localparam logic [GAIN_W-1:0]  KP_RESET    = GAIN_W'(30720);
	localparam logic [GAIN_W-1:0]  KI_RESET    = GAIN_W'(26);
	localparam logic [GAIN_W-1:0]  KD_RESET    = GAIN_W'(128000);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8000);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P = 2'd0,
		REG_GAIN_I = 2'd1,
		REG_GAIN_D = 2'd2,
		REG_LIMIT  = 2'd3
	} cfg_reg_t;

	// Gain set handed to the multiplier stages.
	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

	// Word leaving the error and integral stages.
	typedef struct packed {
		logic signed [ERR_W-1:0]          err;
		logic signed [DIFF_W-1:0]         diff;
		logic signed [INTEGRAL_WIDTH-1:0] integ;
	} front_t;

	// Word leaving the multiplier stages.
	typedef struct packed {
		logic signed [PD_W-1:0]     pd_sum;
		logic signed [I_TERM_W-1:0] i_term;
	} terms_t;

endpackage

FILE: rtl/core/pospid_front.sv
// ----------------------------------------------------------------------------
// Position PID error and integral stages
// Registers the position error, then forms the error difference and the
// saturating integral, updating the controller state once per word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pospid_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [pospid_pkg::POS_W-1:0] encoder_position,
	input  logic signed [pospid_pkg::POS_W-1:0] setpoint_position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pospid_pkg::front_t            out_word
);
	import pospid_pkg::*;

	logic                         v_s1;
	logic signed [ERR_W-1:0]      err_s1;
	logic                         v_s2;
	front_t                       word_s2;
	logic signed [INTEGRAL_WIDTH-1:0] integ_q;
	logic signed [ERR_W-1:0]      prev_q;
	logic                         ld_s1;
	logic                         ld_s2;
	logic                         state_adv;
	logic signed [ISUM_W-1:0]     isum;
	logic signed [INTEGRAL_WIDTH-1:0] isat;
	logic signed [DIFF_W-1:0]     diff;

	// Stage loads when empty or when its word moves on.
	assign ld_s2     = !v_s2 || out_ready;
	assign ld_s1     = !v_s1 || ld_s2;
	assign in_ready  = ld_s1;
	assign state_adv = v_s1 && ld_s2;

	// Stage 1: position error, exact in one extra bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			err_s1 <= ERR_W'(encoder_position) - ERR_W'(setpoint_position);
		end
	end

	// Error difference and saturating integral update.
	always_comb begin
		diff = DIFF_W'(err_s1) - DIFF_W'(prev_q);
		isum = ISUM_W'(integ_q) + ISUM_W'(err_s1);
		if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
			isat = isum[ISUM_W-1] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
			                      : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
		end else begin
			isat = isum[INTEGRAL_WIDTH-1:0];
		end
	end

	// Controller state advances with each word entering stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
			v_s2    <= 1'b0;
		end else begin
			if (state_adv) begin
				integ_q <= isat;
				prev_q  <= err_s1;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 2 word register.
	always_ff @(posedge clk) begin
		if (state_adv) begin
			word_s2.err   <= err_s1;
			word_s2.diff  <= diff;
			word_s2.integ <= isat;
		end
	end

	assign out_valid = v_s2;
	assign out_word  = word_s2;

	// The controller state only moves when a word enters stage 2.
	`PP_ASSERT_NEXT(a_state_hold, !state_adv, $stable(integ_q) && $stable(prev_q))

endmodule

FILE: rtl/core/pospid_mult.sv
// ----------------------------------------------------------------------------
// Position PID multiplier stages
// Forms the proportional, derivative and integral products, holds the
// integral term at its magnitude ceiling and adds the proportional and
// derivative terms.
// ----------------------------------------------------------------------------
module pospid_mult (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pospid_pkg::gains_t   gains,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pospid_pkg::front_t   in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pospid_pkg::terms_t   out_word
);
	import pospid_pkg::*;

	localparam logic signed [CMP_W-1:0] I_POS_LIM = CMP_W'(1) <<< HUGE_EXP;
	localparam logic signed [CMP_W-1:0] I_NEG_LIM = -I_POS_LIM;

	logic                          v_s3;
	logic                          v_s4;
	logic                          ld_s3;
	logic                          ld_s4;
	logic signed [P_W-1:0]         p_s3;
	logic signed [D_W-1:0]         d_s3;
	logic signed [HI_PROD_W-1:0]   hi_s3;
	logic [LO_PROD_W-1:0]          lo_s3;
	terms_t                        word_s4;
	logic signed [GAIN_W:0]        kp_s;
	logic signed [GAIN_W:0]        ki_s;
	logic signed [GAIN_W:0]        kd_s;
	logic signed [INT_HI_W-1:0]    integ_hi;
	logic [INT_LO_W-1:0]           integ_lo;
	logic signed [P_W-1:0]         p_prod;
	logic signed [D_W-1:0]         d_prod;
	logic signed [HI_PROD_W-1:0]   hi_prod;
	logic [LO_PROD_W-1:0]          lo_prod;
	logic signed [I_FULL_W-1:0]    i_full;
	logic signed [CMP_W-1:0]       i_ext;
	logic signed [CMP_W-1:0]       i_sat;

	assign ld_s4    = !v_s4 || out_ready;
	assign ld_s3    = !v_s3 || ld_s4;
	assign in_ready = ld_s3;

	// Stage 3 products; the integral is split into two narrow multiplies.
	always_comb begin
		kp_s     = {1'b0, gains.kp};
		ki_s     = {1'b0, gains.ki};
		kd_s     = {1'b0, gains.kd};
		integ_hi = in_word.integ[INTEGRAL_WIDTH-1:INT_LO_W];
		integ_lo = in_word.integ[INT_LO_W-1:0];
		p_prod   = in_word.err * kp_s;
		d_prod   = in_word.diff * kd_s;
		hi_prod  = integ_hi * ki_s;
		lo_prod  = LO_PROD_W'(integ_lo) * LO_PROD_W'(gains.ki);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld_s3) begin
				v_s3 <= in_valid;
			end
			if (ld_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3 && in_valid) begin
			p_s3  <= p_prod;
			d_s3  <= d_prod;
			hi_s3 <= hi_prod;
			lo_s3 <= lo_prod;
		end
	end

	// Stage 4: recombine the integral product and hold it at the ceiling.
	always_comb begin
		i_full = (I_FULL_W'(hi_s3) <<< INT_LO_W) + $signed(I_FULL_W'(lo_s3));
		i_ext  = CMP_W'(i_full);
		if (i_ext > I_POS_LIM) begin
			i_sat = I_POS_LIM;
		end else if (i_ext < I_NEG_LIM) begin
			i_sat = I_NEG_LIM;
		end else begin
			i_sat = i_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4 && v_s3) begin
			word_s4.pd_sum <= PD_W'(p_s3) + PD_W'(d_s3);
			word_s4.i_term <= I_TERM_W'(i_sat);
		end
	end

	assign out_valid = v_s4;
	assign out_word  = word_s4;

endmodule

FILE: rtl/core/pospid_out.sv
// ----------------------------------------------------------------------------
// Position PID output stages
// Adds the three terms, truncates toward zero, clamps to the amplitude limit
// and registers the drive value, PWM compare value and direction pins.
// ----------------------------------------------------------------------------
module pospid_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [pospid_pkg::LIMIT_W-1:0]     limit,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  pospid_pkg::terms_t                 in_word,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pospid_pkg::DRIVE_W-1:0] drive_value,
	output logic [pospid_pkg::LIMIT_W-1:0]     pwm_compare,
	output logic                               dir_pin_a,
	output logic                               dir_pin_b
);
	import pospid_pkg::*;

	logic                       v_s5;
	logic                       v_s6;
	logic                       ld_s5;
	logic                       ld_s6;
	logic signed [SUM_W-1:0]    sum_s5;
	logic [SUM_W-1:0]           mag;
	logic [Q_W-1:0]             q_full;
	logic [LIMIT_W-1:0]         q;
	logic                       neg;
	logic signed [DRIVE_W-1:0]  drive_value_s6;
	logic [LIMIT_W-1:0]         pwm_compare_s6;
	logic                       dir_neg_s6;

	assign ld_s6    = !v_s6 || out_ready;
	assign ld_s5    = !v_s5 || ld_s6;
	assign in_ready = ld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld_s5) begin
				v_s5 <= in_valid;
			end
			if (ld_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// Stage 5: total of the three terms.
	always_ff @(posedge clk) begin
		if (ld_s5 && in_valid) begin
			sum_s5 <= SUM_W'(in_word.pd_sum) + SUM_W'(in_word.i_term);
		end
	end

	// Truncation toward zero works on the magnitude, then the clamp.
	always_comb begin
		mag    = sum_s5[SUM_W-1] ? SUM_W'(-sum_s5) : SUM_W'(sum_s5);
		q_full = mag[SUM_W-1:GAIN_FRAC_BITS];
		if (q_full > Q_W'(limit)) begin
			q = limit;
		end else begin
			q = q_full[LIMIT_W-1:0];
		end
		neg = sum_s5[SUM_W-1] && (q != '0);
	end

	// Stage 6: result register.
	always_ff @(posedge clk) begin
		if (ld_s6 && v_s5) begin
			drive_value_s6 <= neg ? -$signed(DRIVE_W'(q)) : $signed(DRIVE_W'(q));
			pwm_compare_s6 <= q;
			dir_neg_s6     <= neg;
		end
	end

	assign out_valid   = v_s6;
	assign drive_value = drive_value_s6;
	assign pwm_compare = pwm_compare_s6;
	assign dir_pin_a   = dir_neg_s6;
	assign dir_pin_b   = !dir_neg_s6;

endmodule

FILE: rtl/core/position_pid_motor_drive.sv
// ----------------------------------------------------------------------------
// Position PID motor drive
// Positional PID controller with saturating integral, clamped drive output,
// PWM compare magnitude and direction pins.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   sample  | in_valid, in_ready, encoder_position,          | in
//           | setpoint_position                              |
//   drive   | out_valid, out_ready, drive_value, pwm_compare,| out
//           | dir_pin_a, dir_pin_b                           |
//   config  | cfg_write_en, cfg_index, cfg_data              | in
//
// One word is taken every cycle while results drain. The drive word for a
// sample passes through six pipeline stages (error, integral, products,
// integral ceiling, term sum, clamp and result register).
// Every stage holds its word while the next is full, so a stalled result
// stops only the stages behind it; empty stages still take new words.
// Reset clears the controller state, the pipeline and loads default gains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module position_pid_motor_drive (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [pospid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pospid_pkg::GAIN_W-1:0]      cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [pospid_pkg::POS_W-1:0] encoder_position,
	input  logic signed [pospid_pkg::POS_W-1:0] setpoint_position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pospid_pkg::DRIVE_W-1:0] drive_value,
	output logic [pospid_pkg::LIMIT_W-1:0]     pwm_compare,
	output logic                               dir_pin_a,
	output logic                               dir_pin_b
);
	import pospid_pkg::*;

	gains_t              gains_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic                front_valid;
	logic                front_ready;
	front_t              front_word;
	logic                mult_valid;
	logic                mult_ready;
	terms_t              mult_word;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp <= KP_RESET;
			gains_q.ki <= KI_RESET;
			gains_q.kd <= KD_RESET;
			limit_q    <= LIMIT_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_P: gains_q.kp <= cfg_data;
				REG_GAIN_I: gains_q.ki <= cfg_data;
				REG_GAIN_D: gains_q.kd <= cfg_data;
				REG_LIMIT:  limit_q    <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	pospid_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.encoder_position  (encoder_position),
		.setpoint_position (setpoint_position),
		.out_valid         (front_valid),
		.out_ready         (front_ready),
		.out_word          (front_word)
	);

	pospid_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_word   (front_word),
		.out_valid (mult_valid),
		.out_ready (mult_ready),
		.out_word  (mult_word)
	);

	pospid_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit       (limit_q),
		.in_valid    (mult_valid),
		.in_ready    (mult_ready),
		.in_word     (mult_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive_value (drive_value),
		.pwm_compare (pwm_compare),
		.dir_pin_a   (dir_pin_a),
		.dir_pin_b   (dir_pin_b)
	);

	// A negative drive always has a non-zero magnitude.
	`PP_ASSERT_IMP(a_neg_nonzero, out_valid && dir_pin_a, pwm_compare != '0 && drive_value[DRIVE_W-1])
	// A non-negative drive equals its PWM compare value.
	`PP_ASSERT_IMP(a_pos_match, out_valid && !dir_pin_a, drive_value == $signed({1'b0, pwm_compare}))

endmodule
